@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the stepper interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never occurs at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

@@ src/tlsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tlsr_pkg
// Types and constants shared by the two-axis line stepper ramp modules.
// ----------------------------------------------------------------------------
package tlsr_pkg;

   // Step counter width; the longest move is 2^COUNT_BITS - 1 steps.
   localparam int COUNT_BITS = 23;
   // Width of a step period in ticks.
   localparam int PERIOD_BITS = 16;
   // Width of the signed delta fields.
   localparam int DELTA_BITS = 24;
   // Bresenham error term carries one sign bit over the step count.
   localparam int ERR_BITS = COUNT_BITS + 1;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam int REQ_TDATA_BITS = 2 * DELTA_BITS;
   localparam int RSP_TDATA_BITS = 8;

   // Ramp zone bounds, counted from either end of the move.
   localparam logic [COUNT_BITS-1:0] ZONE_EDGE   = COUNT_BITS'(200);
   localparam logic [COUNT_BITS-1:0] ZONE_SECOND = COUNT_BITS'(400);
   localparam logic [COUNT_BITS-1:0] ZONE_THIRD  = COUNT_BITS'(600);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [PERIOD_BITS-1:0] RESET_PERIOD_EDGE   = PERIOD_BITS'(1000);
   localparam logic [PERIOD_BITS-1:0] RESET_PERIOD_SECOND = PERIOD_BITS'(200);
   localparam logic [PERIOD_BITS-1:0] RESET_PERIOD_THIRD  = PERIOD_BITS'(160);
   localparam logic [PERIOD_BITS-1:0] RESET_PERIOD_CRUISE = PERIOD_BITS'(133);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_PERIOD_EDGE   = 2'd0,
      CSR_PERIOD_SECOND = 2'd1,
      CSR_PERIOD_THIRD  = 2'd2,
      CSR_PERIOD_CRUISE = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACTION_START = 1'b0,
      ACTION_TICK  = 1'b1
   } action_type;

   typedef struct packed {
      logic [PERIOD_BITS-1:0] edge_zone;
      logic [PERIOD_BITS-1:0] second_zone;
      logic [PERIOD_BITS-1:0] third_zone;
      logic [PERIOD_BITS-1:0] cruise_zone;
   } period_set_type;

   typedef struct packed {
      action_type                    action;
      logic signed [DELTA_BITS-1:0]  delta_x;
      logic signed [DELTA_BITS-1:0]  delta_y;
   } req_item_type;

   typedef struct packed {
      logic start_refused;
      logic finished;
      logic running;
      logic heading_y;
      logic heading_x;
      logic pulse_y;
      logic pulse_x;
   } rsp_flags_type;

endpackage

@@ src/tlsr_csr.sv @@
// ----------------------------------------------------------------------------
// tlsr_csr
// Ramp period registers, written through a plain write port.
// ----------------------------------------------------------------------------
module tlsr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tlsr_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [tlsr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output tlsr_pkg::period_set_type            periods
);

   tlsr_pkg::period_set_type period_ff;
   tlsr_pkg::period_set_type period_in;
   logic [tlsr_pkg::PERIOD_BITS-1:0] wdata;

   assign wdata = tlsr_pkg::PERIOD_BITS'(csr_wdata);

   always_comb begin
      period_in = period_ff;
      if (csr_we) begin
         case (tlsr_pkg::csr_index_type'(csr_addr))
            tlsr_pkg::CSR_PERIOD_EDGE:   period_in.edge_zone   = wdata;
            tlsr_pkg::CSR_PERIOD_SECOND: period_in.second_zone = wdata;
            tlsr_pkg::CSR_PERIOD_THIRD:  period_in.third_zone  = wdata;
            tlsr_pkg::CSR_PERIOD_CRUISE: period_in.cruise_zone = wdata;
            default: period_in = period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff.edge_zone   <= tlsr_pkg::RESET_PERIOD_EDGE;
         period_ff.second_zone <= tlsr_pkg::RESET_PERIOD_SECOND;
         period_ff.third_zone  <= tlsr_pkg::RESET_PERIOD_THIRD;
         period_ff.cruise_zone <= tlsr_pkg::RESET_PERIOD_CRUISE;
      end else begin
         period_ff <= period_in;
      end
   end

   assign periods = period_ff;

endmodule

@@ src/tlsr_engine.sv @@
// ----------------------------------------------------------------------------
// tlsr_engine
// Move state and the Bresenham step and ramp update per word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlsr_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  tlsr_pkg::req_item_type      item,
   input  tlsr_pkg::period_set_type    periods,
   output tlsr_pkg::rsp_flags_type     result
);

   localparam int CB = tlsr_pkg::COUNT_BITS;
   localparam int EB = tlsr_pkg::ERR_BITS;
   localparam int PB = tlsr_pkg::PERIOD_BITS;
   localparam int DB = tlsr_pkg::DELTA_BITS;
   localparam int MB = (DB > CB) ? DB : CB;

   logic [CB-1:0]        major_ff, major_in;
   logic [CB-1:0]        minor_ff, minor_in;
   logic [CB-1:0]        index_ff, index_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic                 x_major_ff, x_major_in;
   logic                 dir_x_ff, dir_x_in;
   logic                 dir_y_ff, dir_y_in;
   logic [PB-1:0]        wait_ff, wait_in;
   logic                 busy_ff, busy_in;

   logic [CB-1:0]        mag_x, mag_y;
   logic                 start_x_major;
   logic [CB-1:0]        start_major;
   logic [PB-1:0]        wait_dec;
   logic signed [EB-1:0] err_sub;
   logic [PB-1:0]        zone_period;
   logic [PB-1:0]        next_period;

   // Absolute value, saturated to the longest move the counters hold.
   function automatic logic [CB-1:0] magnitude(input logic signed [DB-1:0] d);
      logic [DB-1:0] a;
      logic [MB-1:0] a_wide;
      a = d[DB-1] ? DB'(-d) : DB'(d);
      a_wide = MB'(a);
      if (a_wide > MB'(tlsr_pkg::COUNT_MAX)) begin
         return tlsr_pkg::COUNT_MAX;
      end
      return CB'(a_wide);
   endfunction

   // Within n steps of the start, or of the end when the move is that long.
   function automatic logic in_zone(input logic [CB-1:0] i, input logic [CB-1:0] n,
                                    input logic [CB-1:0] len);
      return (i < n) || ((len >= n) && (i > (len - n)));
   endfunction

   assign mag_x         = magnitude(item.delta_x);
   assign mag_y         = magnitude(item.delta_y);
   assign start_x_major = mag_x >= mag_y;
   assign start_major   = start_x_major ? mag_x : mag_y;

   assign wait_dec = (wait_ff != '0) ? wait_ff - PB'(1) : wait_ff;
   assign err_sub  = err_ff - EB'(signed'({1'b0, minor_ff}));

   always_comb begin
      if (in_zone(index_ff, tlsr_pkg::ZONE_EDGE, major_ff)) begin
         zone_period = periods.edge_zone;
      end else if (in_zone(index_ff, tlsr_pkg::ZONE_SECOND, major_ff)) begin
         zone_period = periods.second_zone;
      end else if (in_zone(index_ff, tlsr_pkg::ZONE_THIRD, major_ff)) begin
         zone_period = periods.third_zone;
      end else begin
         zone_period = periods.cruise_zone;
      end
   end

   // A zero period behaves as one tick.
   assign next_period = (zone_period == '0) ? PB'(1) : zone_period;

   always_comb begin
      major_in   = major_ff;
      minor_in   = minor_ff;
      index_in   = index_ff;
      err_in     = err_ff;
      x_major_in = x_major_ff;
      dir_x_in   = dir_x_ff;
      dir_y_in   = dir_y_ff;
      wait_in    = wait_ff;
      busy_in    = busy_ff;
      result     = '0;

      if (item.action == tlsr_pkg::ACTION_START) begin
         if (busy_ff) begin
            result.start_refused = 1'b1;
         end else begin
            if (item.delta_x != '0) begin
               dir_x_in = !item.delta_x[DB-1];
            end
            if (item.delta_y != '0) begin
               dir_y_in = !item.delta_y[DB-1];
            end
            x_major_in = start_x_major;
            major_in   = start_major;
            minor_in   = start_x_major ? mag_y : mag_x;
            err_in     = EB'(signed'({1'b0, start_major >> 1}));
            index_in   = '0;
            wait_in    = '0;
            if (start_major == '0) begin
               result.finished = 1'b1;
            end else begin
               busy_in = 1'b1;
            end
         end
      end else if (busy_ff) begin
         wait_in = wait_dec;
         if (wait_dec == '0) begin
            if (index_ff >= major_ff) begin
               busy_in         = 1'b0;
               result.finished = 1'b1;
            end else begin
               if (err_sub < 0) begin
                  err_in = err_sub + EB'(signed'({1'b0, major_ff}));
                  result.pulse_x = 1'b1;
                  result.pulse_y = 1'b1;
               end else begin
                  err_in = err_sub;
               end
               // The major axis always steps; the minor one only on a carry.
               if (x_major_ff) begin
                  result.pulse_x = 1'b1;
               end else begin
                  result.pulse_y = 1'b1;
               end
               wait_in  = next_period;
               index_in = index_ff + CB'(1);
            end
         end
      end

      result.heading_x = dir_x_in;
      result.heading_y = dir_y_in;
      result.running   = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff   <= '0;
         minor_ff   <= '0;
         index_ff   <= '0;
         err_ff     <= '0;
         x_major_ff <= 1'b1;
         dir_x_ff   <= 1'b0;
         dir_y_ff   <= 1'b0;
         wait_ff    <= '0;
         busy_ff    <= 1'b0;
      end else if (fire) begin
         major_ff   <= major_in;
         minor_ff   <= minor_in;
         index_ff   <= index_in;
         err_ff     <= err_in;
         x_major_ff <= x_major_in;
         dir_x_ff   <= dir_x_in;
         dir_y_ff   <= dir_y_in;
         wait_ff    <= wait_in;
         busy_ff    <= busy_in;
      end
   end

   `ASSERT_CLK(a_pulse_needs_busy_tick, clock, reset,
      (result.pulse_x || result.pulse_y) |-> (busy_ff && item.action == tlsr_pkg::ACTION_TICK),
      "step pulse without a running move and a tick")
   `ASSERT_CLK(a_major_axis_steps, clock, reset,
      (result.pulse_x || result.pulse_y) |-> (x_major_ff ? result.pulse_x : result.pulse_y),
      "minor axis pulsed without the major axis")
   `ASSERT_CLK(a_index_bounded, clock, reset, busy_ff |-> (index_ff <= major_ff),
      "step index ran past the major length")
   `ASSERT_CLK(a_error_nonnegative, clock, reset, busy_ff |-> !err_ff[EB-1],
      "error term negative between steps")
   `ASSERT_NEVER(a_finished_not_running, clock, reset, result.finished && result.running,
      "finished reported while still running")

endmodule

@@ src/two_axis_line_stepper_ramp_core.sv @@
// ----------------------------------------------------------------------------
// two_axis_line_stepper_ramp_core
// Two-axis Bresenham line interpolator with a four-zone step period ramp.
// ----------------------------------------------------------------------------
// Usage. Words enter on the req_ stream: req_tuser selects a start (0) or a
// time tick (1), and req_tdata carries the signed X and Y deltas used by a
// start. Every accepted word yields exactly one word on the rsp_ stream with
// the step pulses, the axis directions and the running, finished and refused
// flags. The four ramp periods are written over the csr_ port, by the user
// only while the block is idle; the block itself does not enforce this.
// A word is captured in the input register; once the output register is
// free, the step update is applied to the move state and the result lands
// in the output register. One word per cycle is taken while the receiver
// keeps up, as the update from the input register to the result register
// is combinational; a tick that arrives every cycle is handled exactly.
// Reset (synchronous, active high) clears both stream stages, restores the
// reset periods and leaves no move running. When the receiver holds
// rsp_tready low, the result waits in the output register, the input
// register still takes one more word, and req_tready drops only once both
// are full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module two_axis_line_stepper_ramp_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request stream.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: delta_x[23:0], delta_y[47:24].
   input  logic [tlsr_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // Fields from bit 0: action.
   input  logic                                  req_tuser,
   // Response stream.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0: pulse_x, pulse_y, heading_x, heading_y, running,
   // finished, start_refused, one zero pad bit.
   output logic [tlsr_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // Period register write port.
   input  logic                                  csr_we,
   input  logic [tlsr_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [tlsr_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int DB = tlsr_pkg::DELTA_BITS;

   // Input stage.
   logic                     in_vld_ff, in_vld_in;
   tlsr_pkg::req_item_type   in_item_ff;

   // Output stage.
   logic                     out_vld_ff, out_vld_in;
   tlsr_pkg::rsp_flags_type  out_flags_ff;

   logic                     req_accept;
   logic                     out_free;
   logic                     fire;
   tlsr_pkg::period_set_type periods;
   tlsr_pkg::rsp_flags_type  result;

   // The output register frees up in the same cycle its word is taken, so
   // the input stage can move on every cycle the receiver keeps up.
   assign out_free   = !out_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end

      if (fire) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.action  <= tlsr_pkg::action_type'(req_tuser);
         in_item_ff.delta_x <= signed'(req_tdata[DB-1:0]);
         in_item_ff.delta_y <= signed'(req_tdata[2*DB-1:DB]);
      end
      if (fire) begin
         out_flags_ff <= result;
      end
   end

   tlsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .periods   (periods)
   );

   tlsr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (in_item_ff),
      .periods (periods),
      .result  (result)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = tlsr_pkg::RSP_TDATA_BITS'(out_flags_ff);

endmodule
